// ===== hw/rtl/ecvm_pkg.sv =====
`default_nettype none
package ecvm_pkg;
    localparam int ANG_W = 16;
    localparam int POS_W = 24;
    localparam int VEC_W = 16;
    localparam int TRN_W = 27;
    localparam int IN_W  = 2 * ANG_W + 3 * POS_W;
    localparam int OUT_W = 9 * VEC_W + 3 * TRN_W;
    localparam int IN_BYTES_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
    localparam int STAGES = 8;
    localparam logic [17:0] TURN_K = 18'd166886;
    localparam logic [15:0] SIN_A = 16'd25736;
    localparam logic [15:0] SIN_B = 16'd10512;
    localparam logic [15:0] SIN_C = 16'd1160;
    localparam logic signed [TRN_W-1:0] TRN_MAX = 27'sd67108863;
    localparam logic signed [TRN_W-1:0] TRN_MIN = -27'sd67108863 - 27'sd1;

    typedef logic signed [16:0] q14_t;
    typedef logic signed [49:0] acc_t;
    typedef logic signed [TRN_W-1:0] trn_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] pitch;
        logic signed [ANG_W-1:0] yaw;
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
        logic [15:0] pp;
        logic [15:0] yp;
        logic [3:0][15:0] zs;
        logic [3:0][1:0]  qs;
        logic [3:0][15:0] z2s;
        logic [3:0][15:0] ts;
        logic signed [16:0] sp;
        logic signed [16:0] cp;
        logic signed [16:0] sy;
        logic signed [16:0] cy;
        q14_t [8:0] v;
        acc_t [2:0] acc;
        trn_t [2:0] tr;
    } ecvm_data_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ecvm_cell.sv =====
`default_nettype none
module ecvm_cell #(
    parameter int STEP = 0
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic vld_in,
    input  wire ecvm_pkg::ecvm_data_t d_in,
    output logic vld_out,
    output ecvm_pkg::ecvm_data_t d_out
);
    import ecvm_pkg::*;

    logic vld_reg;
    ecvm_data_t d_reg, d_next;

    function automatic logic signed [16:0] rnd14(input logic signed [33:0] p);
        logic signed [33:0] s;
        s = p + 34'sd8192;
        return s[30:14];
    endfunction

    always_comb begin
        logic signed [34:0] pa;
        logic signed [34:0] pb;
        logic [31:0] m;
        logic signed [16:0] g;
        logic signed [49:0] sm;
        logic signed [50:0] rr;
        d_next = d_in;
        pa = '0;
        pb = '0;
        m = '0;
        g = '0;
        sm = '0;
        rr = '0;
        case (STEP)
            0: begin
                pa = 35'(d_in.pitch) * $signed({17'd0, TURN_K}) + 35'sd32768;
                pb = 35'(d_in.yaw) * $signed({17'd0, TURN_K}) + 35'sd32768;
                d_next.pp = pa[31:16];
                d_next.yp = pb[31:16];
            end
            1: begin
                for (int i = 0; i < 4; i++) begin
                    logic [15:0] ph;
                    ph = (i == 0) ? d_in.pp : (i == 1) ? d_in.pp + 16'd16384 :
                         (i == 2) ? d_in.yp : d_in.yp + 16'd16384;
                    d_next.qs[i] = ph[15:14];
                    d_next.zs[i] = ph[14] ? 16'd16384 - {2'b0, ph[13:0]}
                                          : {2'b0, ph[13:0]};
                    m = d_next.zs[i] * d_next.zs[i];
                    d_next.z2s[i] = m[29:14];
                end
            end
            2: begin
                for (int i = 0; i < 4; i++) begin
                    m = SIN_C * d_in.z2s[i];
                    d_next.ts[i] = SIN_B - m[29:14];
                end
            end
            3: begin
                for (int i = 0; i < 4; i++) begin
                    m = d_in.ts[i] * d_in.z2s[i];
                    d_next.ts[i] = SIN_A - m[29:14];
                end
            end
            4: begin
                logic signed [16:0] s [4];
                for (int i = 0; i < 4; i++) begin
                    m = d_in.ts[i] * d_in.zs[i];
                    s[i] = d_in.qs[i][1] ? -$signed({1'b0, m[29:14]})
                                         : $signed({1'b0, m[29:14]});
                end
                d_next.sp = s[0];
                d_next.cp = s[1];
                d_next.sy = s[2];
                d_next.cy = s[3];
            end
            5: begin
                g = (d_in.cp > 0) ? 17'sd1 : (d_in.cp < 0) ? -17'sd1 : 17'sd0;
                d_next.v[0] = -(g * d_in.cy);
                d_next.v[1] = '0;
                d_next.v[2] = g * d_in.sy;
                d_next.v[3] = rnd14(34'(-(g * d_in.sy)) * 34'(d_in.sp));
                d_next.v[4] = g * d_in.cp;
                d_next.v[5] = rnd14(34'(-(g * d_in.cy)) * 34'(d_in.sp));
                d_next.v[6] = rnd14(34'(d_in.sy) * 34'(d_in.cp));
                d_next.v[7] = d_in.sp;
                d_next.v[8] = rnd14(34'(d_in.cy) * 34'(d_in.cp));
            end
            6: begin
                for (int i = 0; i < 3; i++) begin
                    sm = 50'(d_in.v[3*i]) * 50'(d_in.px)
                       + 50'(d_in.v[3*i+1]) * 50'(d_in.py)
                       + 50'(d_in.v[3*i+2]) * 50'(d_in.pz);
                    d_next.acc[i] = sm;
                end
            end
            default: begin
                for (int i = 0; i < 3; i++) begin
                    rr = (-51'(d_in.acc[i]) + 51'sd8192) >>> 14;
                    if (rr > 51'(TRN_MAX)) d_next.tr[i] = TRN_MAX;
                    else if (rr < 51'(TRN_MIN)) d_next.tr[i] = TRN_MIN;
                    else d_next.tr[i] = rr[TRN_W-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out = d_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/euler_camera_view_matrix.sv =====
// Each input beat passes through the eight cell registers in order to the output beat.
// Throughput: one pose per cycle; the eight-cell pipeline advances whenever its
// output register is empty or being drained.
// Reset: synchronous active-low aresetn clears all valid flags; no data is held.
`default_nettype none
module euler_camera_view_matrix (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic s_tready,
    // pitch_angle, yaw_angle, pos_x, pos_y, pos_z
    input  wire logic [ecvm_pkg::IN_BYTES_W-1:0] s_tdata,
    output logic m_tvalid,
    input  wire logic m_tready,
    // right_x..z, up_x..z, dir_x..z, trans_right, trans_up, trans_dir, zero fill
    output logic [ecvm_pkg::OUT_BYTES_W-1:0] m_tdata
);
    import ecvm_pkg::*;

    logic en;
    logic vld [STAGES+1];
    ecvm_data_t dat [STAGES+1];

    assign en = !vld[STAGES] || m_tready;
    assign s_tready = en;

    always_comb begin
        dat[0] = '0;
        dat[0].pitch = s_tdata[15:0];
        dat[0].yaw = s_tdata[31:16];
        dat[0].px = s_tdata[55:32];
        dat[0].py = s_tdata[79:56];
        dat[0].pz = s_tdata[103:80];
    end
    assign vld[0] = s_tvalid;

    for (genvar k = 0; k < STAGES; k++) begin : g_cell
        ecvm_cell #(.STEP(k)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(vld[k]), .d_in(dat[k]),
            .vld_out(vld[k+1]), .d_out(dat[k+1])
        );
    end

    assign m_tvalid = vld[STAGES];
    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < 9; i++) begin
            m_tdata[i*VEC_W +: VEC_W] = dat[STAGES].v[i][VEC_W-1:0];
        end
        for (int i = 0; i < 3; i++) begin
            m_tdata[9*VEC_W + i*TRN_W +: TRN_W] = dat[STAGES].tr[i];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output drain");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_BYTES_W-1:OUT_W] == '0)
        else $error("fill bits not zero");
endmodule
`default_nettype wire
